// ===== rtl/core/bit_packed_store_unit_macros.svh =====
// Assertion macros for the bit-packed store unit.
// Used by the port checker; needs nothing else.
`ifndef BIT_PACKED_STORE_UNIT_MACROS_SVH
`define BIT_PACKED_STORE_UNIT_MACROS_SVH

// Same-cycle implication.
`define BPS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bps_pkg.sv =====
// Shared constants and types for the bit-packed store unit.
// No dependencies.
`default_nettype none
package bps_pkg;
  localparam int STORE_BYTES = 256;
  localparam int STORE_BITS  = STORE_BYTES * 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int FIELD_MAX   = 64;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [3:0]  take;
    logic [7:0]  wdata;
    logic [63:0] acc;
    logic [63:0] aligned;
  } step_t;
endpackage
`default_nettype wire

// ===== rtl/core/bps_store.sv =====
// Byte store with per-byte valid bits, one write and one registered read per cycle.
// Depends on bps_pkg.
`default_nettype none
module bps_store
  import bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       we,
  input  addr_t      waddr,
  input  logic [7:0] wdata,
  input  addr_t      raddr,
  output logic [7:0] rdata
);
  logic [7:0]             mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] vld;
  logic [7:0]             mem_q;
  logic                   vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
    vld_q <= vld[raddr];
  end

  assign rdata = vld_q ? mem_q : 8'h00;
endmodule
`default_nettype wire

// ===== rtl/core/bps_step.sv =====
// Shared byte unit: merges or extracts the part of a field that lies in one byte.
// Depends on bps_pkg.
`default_nettype none
module bps_step
  import bps_pkg::*;
(
  input  logic [7:0]  rdata,
  input  logic [2:0]  off,
  input  logic [6:0]  rem,
  input  logic [63:0] aligned,
  input  logic [63:0] acc,
  output step_t       step
);
  logic [3:0] avail;
  logic [3:0] take;
  logic [3:0] rshift;
  logic [7:0] masked;
  logic [7:0] bits;

  always_comb begin
    avail   = 4'd8 - {1'b0, off};
    take    = (rem < {3'b000, avail}) ? rem[3:0] : avail;
    rshift  = avail - take;
    masked  = rdata & (8'hFF >> off);
    bits    = masked >> rshift;
    step.take    = take;
    step.wdata   = rdata | (aligned[63:56] >> off);
    step.acc     = (acc << take) | {56'h0, bits};
    step.aligned = aligned << take;
  end
endmodule
`default_nettype wire

// ===== rtl/core/bit_packed_store_unit.sv =====
// Bit-packed byte store with MSB-first append and extract of 0..64-bit fields.
// The result word is offered once every byte the field touches (1..9) has been
// worked; a zero-width or out-of-range item skips the byte pass. The next word
// can be taken in the cycle after the result loads, later while an earlier result
// waits on out_ready. The store serves one byte read and one byte write per cycle.
// One item is worked at a time. The store clears at reset through per-byte
// valid bits, so no clearing pass is needed. Depends on bps_pkg, bps_store, bps_step.
`default_nettype none
module bit_packed_store_unit
  import bps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [63:0] value,
  input  logic [6:0]  width,
  input  logic [10:0] bit_pos,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value_out,
  output logic [11:0] end_pos,
  output logic        status
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state;
  logic        is_ext;
  logic [11:0] cur;
  logic [6:0]  rem;
  logic [63:0] aligned;
  logic [63:0] acc;
  logic [11:0] nb;
  logic        st;

  logic [11:0] sum;
  logic        err;
  logic [11:0] cur_next;
  logic [6:0]  rem_next;
  logic        load;
  logic        we;
  addr_t       raddr;
  logic [7:0]  rdata;
  step_t       step;

  assign in_ready = (state == S_IDLE);
  assign sum      = {1'b0, bit_pos} + {5'b0, width};
  assign err      = (width > 7'(FIELD_MAX)) || (int'(sum) > STORE_BITS);
  assign cur_next = cur + {8'b0, step.take};
  assign rem_next = rem - {3'b0, step.take};
  assign load     = (state == S_DONE) && (!out_valid || out_ready);
  assign we       = (state == S_RUN) && !is_ext;
  assign raddr    = (state == S_IDLE) ? addr_t'(bit_pos >> 3) : addr_t'(cur_next >> 3);

  bps_store u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (addr_t'(cur >> 3)),
    .wdata (step.wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bps_step u_step (
    .rdata   (rdata),
    .off     (cur[2:0]),
    .rem     (rem),
    .aligned (aligned),
    .acc     (acc),
    .step    (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (err || width == 7'd0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (rem_next == 7'd0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      is_ext  <= cmd;
      acc     <= '0;
      nb      <= err ? {1'b0, bit_pos} : sum;
      st      <= err;
      cur     <= {1'b0, bit_pos};
      rem     <= width;
      aligned <= value << (7'd64 - width);
    end else if (state == S_RUN) begin
      cur     <= cur_next;
      rem     <= rem_next;
      aligned <= step.aligned;
      if (is_ext) begin
        acc <= step.acc;
      end
    end
    if (load) begin
      value_out <= acc;
      end_pos   <= nb;
      status    <= st;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bps_checker.sv =====
// Port-level checker for the bit-packed store unit, bound to the top level.
// Depends on bps_pkg and bit_packed_store_unit_macros.svh.
`default_nettype none
`include "bit_packed_store_unit_macros.svh"
module bps_checker
  import bps_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value_out,
  input logic [11:0] end_pos,
  input logic        status
);
  `BPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(value_out) && $stable(end_pos) && $stable(status),
    "result word changed while stalled")
  `BPS_ASSERT_SAME(a_err_zero, clk, rst, out_valid && status, value_out == 64'h0,
    "error result carries nonzero data")
  `BPS_ASSERT_SAME(a_ok_range, clk, rst, out_valid && !status,
    int'(end_pos) <= STORE_BITS, "ok result points past the store")
  `BPS_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready,
    "input taken while an item is in progress")
endmodule

bind bit_packed_store_unit bps_checker u_bps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value_out (value_out),
  .end_pos   (end_pos),
  .status    (status)
);
`default_nettype wire

// ===== tb/bit_packed_store_check.sv =====
`timescale 1ns / 100ps
// Checker for bit_packed_store_unit: keeps a shadow of the byte store, predicts one
// reply per accepted word and compares replies in order. Depends on bps_pkg.
module bit_packed_store_check
  import bps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [63:0] value,
  input  logic [6:0]  width,
  input  logic [10:0] bit_pos,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] value_out,
  input  logic [11:0] end_pos,
  input  logic        status,
  output int          fails,
  output int          pending,
  output int          replies,
  output int          range_hits
);
  localparam logic CMD_APPEND = 1'b0;
  localparam int   PRINT_CAP  = 40;

  typedef struct packed {
    logic [63:0] bits;
    logic [11:0] next;
    logic        err;
  } reply_t;

  logic [7:0] shadow [STORE_BYTES];
  reply_t     replies_due [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fails < PRINT_CAP)
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fails = fails + 1;
  endtask

  // Append ORs the low nbits of val in MSB-first; extract shifts bits in MSB-first.
  function automatic reply_t store_field(input logic op, input logic [63:0] val,
                                         input int unsigned nbits, input int unsigned pos);
    reply_t      r;
    int unsigned at;
    r = '0;
    r.next = pos[11:0];
    if (nbits > FIELD_MAX || pos + nbits > STORE_BITS) begin
      r.err = 1'b1;
      return r;
    end
    for (int unsigned i = 0; i < nbits; i++) begin
      at = pos + i;
      if (op == CMD_APPEND) begin
        if (val[nbits - 1 - i])
          shadow[at / 8][7 - at % 8] = 1'b1;
      end else begin
        r.bits = {r.bits[62:0], shadow[at / 8][7 - at % 8]};
      end
    end
    r.next = 12'(pos + nbits);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      foreach (shadow[k])
        shadow[k] = '0;
      replies_due.delete();
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        replies = replies + 1;
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply value_out", value_out, '0);
        end else begin
          want = replies_due.pop_front();
          if (want.err)
            range_hits = range_hits + 1;
          if (value_out !== want.bits)
            report_mismatch("value_out", value_out, want.bits);
          if (end_pos !== want.next)
            report_mismatch("end_pos", 64'(end_pos), 64'(want.next));
          if (status !== want.err)
            report_mismatch("status", 64'(status), 64'(want.err));
        end
      end
      if (in_valid && in_ready)
        replies_due.push_back(store_field(cmd, value, width, bit_pos));
      pending = replies_due.size();
    end
  end
endmodule

// ===== tb/tb_bit_packed_store_unit.sv =====
`timescale 1ns / 100ps
// Top of the bit_packed_store_unit testbench: directed and random append/extract words
// with random gaps on both channels. Uses bps_pkg, the DUT, bit_packed_store_check.
module tb_bit_packed_store_unit;
  import bps_pkg::*;

  localparam logic CMD_APPEND   = 1'b0;
  localparam logic CMD_EXTRACT  = 1'b1;
  localparam int   RANDOM_WORDS = 1200;
  localparam int   LONG_HOLD    = 400;
  localparam int   IDLE_LIMIT   = 4000;
  localparam int   DRAIN_CYCLES = 24;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        out_ready = 1'b0;
  logic        cmd       = CMD_APPEND;
  logic [63:0] value     = '0;
  logic [6:0]  width     = '0;
  logic [10:0] bit_pos   = '0;
  logic        in_ready;
  logic        out_valid;
  logic [63:0] value_out;
  logic [11:0] end_pos;
  logic        status;

  int   fails;
  int   pending;
  int   replies;
  int   range_hits;
  int   appends;
  int   extracts;
  int   idle_cycles;
  int   squeezes;
  logic steady = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bit_packed_store_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .value     (value),
    .width     (width),
    .bit_pos   (bit_pos),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_out (value_out),
    .end_pos   (end_pos),
    .status    (status)
  );

  bit_packed_store_check CHK (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .value      (value),
    .width      (width),
    .bit_pos    (bit_pos),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value_out  (value_out),
    .end_pos    (end_pos),
    .status     (status),
    .fails      (fails),
    .pending    (pending),
    .replies    (replies),
    .range_hits (range_hits)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 85)
      return $urandom_range(1, 3);
    if (roll < 96)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic op, input logic [63:0] val,
                           input logic [6:0] nbits, input logic [10:0] pos);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    value    <= val;
    width    <= nbits;
    bit_pos  <= pos;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    if (op == CMD_APPEND)
      appends++;
    else
      extracts++;
    @(negedge clk);
  endtask

  task automatic random_word();
    logic        op;
    logic [63:0] val;
    int          nbits;
    int          pos;
    int          roll;
    op = ($urandom_range(0, 99) < 30) ? CMD_APPEND : CMD_EXTRACT;
    roll = $urandom_range(0, 99);
    if (roll < 10)
      nbits = FIELD_MAX;
    else if (roll < 15)
      nbits = 0;
    else if (roll < 20)
      nbits = $urandom_range(FIELD_MAX + 1, 127);
    else if (roll < 35)
      nbits = $urandom_range(1, 8);
    else
      nbits = $urandom_range(1, FIELD_MAX - 1);
    roll = $urandom_range(0, 99);
    if (roll < 10 || nbits > FIELD_MAX)
      pos = $urandom_range(0, STORE_BITS - 1);
    else if (roll < 22)
      pos = $urandom_range(STORE_BITS - FIELD_MAX - 8, STORE_BITS - 1);
    else
      pos = $urandom_range(0, STORE_BITS - ((nbits > 0) ? nbits : 1));
    roll = $urandom_range(0, 9);
    val = {$urandom, $urandom};
    if (roll < 8)
      val = val & {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    else if (roll == 9)
      val = '1;
    send_word(op, val, 7'(nbits), 11'(pos));
  endtask

  initial begin : receiver
    int span;
    int roll;
    @(negedge clk);
    forever begin
      if (squeezes < 2 && replies >= 150 + 650 * squeezes) begin
        squeezes++;
        out_ready <= 1'b0;
        span = LONG_HOLD;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          out_ready <= 1'b1;
          span = $urandom_range(1, 24);
        end else if (roll < 60) begin
          out_ready <= 1'b1;
          span = $urandom_range(60, 150);
        end else if (roll < 92) begin
          out_ready <= 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          span = $urandom_range(10, 50);
        end
      end
      repeat (span) @(negedge clk);
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_word(CMD_EXTRACT, '0, 64, 0);
    send_word(CMD_APPEND, '1, 0, 5);
    send_word(CMD_APPEND, 64'hA5C3_0F96_5A3C_F069, 64, 3);
    send_word(CMD_EXTRACT, '0, 64, 3);
    send_word(CMD_EXTRACT, '1, 64, 0);
    send_word(CMD_APPEND, '1, 1, 2047);
    send_word(CMD_EXTRACT, '0, 1, 2047);
    send_word(CMD_APPEND, '1, 2, 2047);
    send_word(CMD_EXTRACT, '0, 64, 1985);
    send_word(CMD_APPEND, 64'hDEAD_BEEF_0123_4567, 64, 1984);
    send_word(CMD_EXTRACT, '0, 64, 1984);
    send_word(CMD_APPEND, '1, 65, 0);
    send_word(CMD_EXTRACT, '1, 127, 0);
    send_word(CMD_APPEND, '1, 7, 100);
    send_word(CMD_EXTRACT, '0, 16, 96);
    send_word(CMD_APPEND, 64'h5, 3, 120);
    send_word(CMD_APPEND, 64'h2, 3, 120);
    send_word(CMD_EXTRACT, '0, 8, 118);
    send_word(CMD_EXTRACT, '0, 0, 2047);
    send_word(CMD_APPEND, '0, 64, 2047);
    send_word(CMD_APPEND, 64'h8000_0000_0000_0001, 64, 1024);
    send_word(CMD_EXTRACT, '0, 64, 1024);
    send_word(CMD_EXTRACT, '0, 63, 1025);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      steady = (k >= 400 && k < 460);
      random_word();
    end
    in_valid <= 1'b0;

    while (pending != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d words (%0d appends, %0d extracts) and %0d replies,",
             appends + extracts, appends, extracts, replies);
    $display("%0d past capacity; receiver held off %0d times for %0d cycles under load.",
             range_hits, squeezes, LONG_HOLD);
    if (fails == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bps_pkg.sv
rtl/core/bps_store.sv
rtl/core/bps_step.sv
rtl/core/bit_packed_store_unit.sv
rtl/core/bps_checker.sv
tb/bit_packed_store_check.sv
tb/tb_bit_packed_store_unit.sv
